### src/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants of the ASCII85 stream encoder
// Character codes, reciprocal constants for the base-85 split, queue sizing
// and the structs passed between the front, the converter and the emitter.
// ----------------------------------------------------------------------------
package a85_pkg;

  // Characters
  localparam logic [7:0] CharNl    = 8'd10;
  localparam logic [7:0] CharBase  = 8'd33;   // '!' offset of a digit
  localparam logic [7:0] CharZero  = 8'd122;  // 'z' for an all-zero group
  localparam logic [7:0] CharTilde = 8'd126;  // '~'
  localparam logic [7:0] CharGt    = 8'd62;   // '>'

  localparam logic [7:0] LineLimitReset = 8'd76;

  // Base-85 split: q = (v * RecipMagic) >> RecipShift is exact for 32-bit v
  localparam int unsigned Radix      = 85;
  localparam logic [31:0] RecipMagic = 32'hC0C0C0C1;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned QuoWidth   = 64 - RecipShift;
  localparam int unsigned DigitCount = 5;
  localparam int unsigned DigitWidth = 7;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [DigitWidth-1:0] digit_t;

  // One request's worth of output, in emission order:
  // [nl_first] [group chars] [nl_second] ['~' '>' newline if eod]
  typedef struct packed {
    logic        nl_first;
    logic        has_grp;
    logic        is_zero;
    logic [2:0]  ndig;
    logic        nl_second;
    logic        eod;
    logic [31:0] value;
  } cmd_t;

  // Converted command: digits[0] is the most significant digit
  typedef struct packed {
    logic                        nl_first;
    logic                        has_grp;
    logic                        is_zero;
    logic [2:0]                  ndig;
    logic                        nl_second;
    logic                        eod;
    logic [DigitCount-1:0][DigitWidth-1:0] digits;
  } res_t;

endpackage

### src/a85_if.sv
// ----------------------------------------------------------------------------
// a85_if: stream channels of the ASCII85 stream encoder
// Input channel carries raw bytes with flags; output channel carries text.
// ----------------------------------------------------------------------------
interface a85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_data;

  modport source (output valid, data_byte, has_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_data, output ready);
endinterface

interface a85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

### src/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front: byte intake and classification
// Packs bytes into groups, tracks the output column and the line limit, and
// pushes one command per request that produces characters.
// ----------------------------------------------------------------------------
module a85_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  a85_in_if.sink         in_i,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output a85_pkg::cmd_t  cmd_o
);

  localparam logic [8:0] ZeroGroupCols = 9'd1;
  localparam logic [8:0] FullGroupCols = 9'd5;

  logic [7:0]  limit_q;
  logic [23:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  col_q, col_d;

  logic        accept;
  logic        full_grp;
  logic [31:0] grp;
  logic        nl_grp;
  logic        nl_end;
  logic [7:0]  col_a, col_b;
  logic [8:0]  col_sum;
  logic [31:0] padded;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && cmd_ready_i;
  assign full_grp   = in_i.has_byte && (cnt_q == 2'd3);
  assign grp        = {pend_q, in_i.data_byte};

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (in_i.has_byte) begin
      if (full_grp) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = {pend_q[15:0], in_i.data_byte};
        cnt_d  = cnt_q + 2'd1;
      end
    end

    // Column check before a full group, then saturating advance
    nl_grp  = full_grp && (col_q >= limit_q);
    col_a   = nl_grp ? '0 : col_q;
    col_sum = {1'b0, col_a} + ((grp == '0) ? ZeroGroupCols : FullGroupCols);
    col_b   = full_grp ? (col_sum[8] ? 8'hFF : col_sum[7:0]) : col_q;
    nl_end  = col_b >= limit_q;

    unique case (cnt_d)
      2'd1:    padded = {pend_d[7:0], 24'h0};
      2'd2:    padded = {pend_d[15:0], 16'h0};
      2'd3:    padded = {pend_d, 8'h0};
      default: padded = '0;
    endcase

    cmd_o = '0;
    if (full_grp) begin
      cmd_o.nl_first  = nl_grp;
      cmd_o.has_grp   = 1'b1;
      cmd_o.is_zero   = (grp == '0);
      cmd_o.ndig      = 3'(a85_pkg::DigitCount);
      cmd_o.nl_second = in_i.end_of_data && nl_end;
      cmd_o.eod       = in_i.end_of_data;
      cmd_o.value     = grp;
    end else begin
      cmd_o.nl_first  = nl_end;
      cmd_o.has_grp   = (cnt_d != 2'd0);
      cmd_o.ndig      = {1'b0, cnt_d} + 3'd1;
      cmd_o.eod       = 1'b1;
      cmd_o.value     = padded;
    end

    // End of data clears the partial group and the column
    col_d = col_b;
    if (in_i.end_of_data) begin
      pend_d = '0;
      cnt_d  = '0;
      col_d  = '0;
    end
  end

  assign cmd_valid_o = accept && (full_grp || in_i.end_of_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= a85_pkg::LineLimitReset;
      pend_q  <= '0;
      cnt_q   <= '0;
      col_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
        col_q  <= col_d;
      end
    end
  end

endmodule

### src/a85_cmdq.sv
// ----------------------------------------------------------------------------
// a85_cmdq: command queue
// Small register FIFO between the front and the converter.
// ----------------------------------------------------------------------------
module a85_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  a85_pkg::cmd_t  push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output a85_pkg::cmd_t  pop_cmd_o
);

  a85_pkg::cmd_t                    mem_q [a85_pkg::QueueDepth];
  logic [a85_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [a85_pkg::QueueCntW-1:0]    cnt_q;
  logic                             push, pop;

  localparam logic [a85_pkg::QueuePtrW-1:0] LastPtr = a85_pkg::QueuePtrW'(a85_pkg::QueueDepth - 1);
  localparam logic [a85_pkg::QueueCntW-1:0] FullCnt = a85_pkg::QueueCntW'(a85_pkg::QueueDepth);

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        mem_q[wr_ptr_q] <= push_cmd_i;
        wr_ptr_q        <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### src/a85_conv.sv
// ----------------------------------------------------------------------------
// a85_conv: base-85 converter
// Splits a 32-bit group into five digits, least significant first, with one
// multiply step and one subtract step for each of the four low digits (the
// last quotient is the leading digit), and holds the result for the emitter.
// ----------------------------------------------------------------------------
module a85_conv (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  a85_pkg::cmd_t  cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output a85_pkg::res_t  res_o
);

  typedef enum logic [1:0] {StIdle, StMul, StSub, StDone} state_e;

  state_e                              state_q;
  a85_pkg::cmd_t                       hdr_q;
  logic [31:0]                         v_q;
  logic [a85_pkg::QuoWidth-1:0]        quo_q, quo_d;
  logic [1:0]                          step_q;
  logic [a85_pkg::DigitCount-1:0][a85_pkg::DigitWidth-1:0] dig_q;

  logic        take;
  logic        needs_dig;
  logic [31:0] mul_in;
  logic [63:0] prod;
  logic [32:0] quo85;
  logic [31:0] diff;
  logic [2:0]  wr_idx;

  assign take        = cmd_valid_i && ((state_q == StIdle) || ((state_q == StDone) && res_ready_i));
  assign cmd_ready_o = take;
  assign needs_dig   = cmd_i.has_grp && !cmd_i.is_zero;

  // Reciprocal multiply; the first step runs on the queue head as it is taken
  assign mul_in = (state_q == StMul) ? v_q : cmd_i.value;
  assign prod   = 64'(mul_in) * 64'(a85_pkg::RecipMagic);
  assign quo_d  = prod[63:a85_pkg::RecipShift];

  // Remainder: v - 85 * q, with 85 = 64 + 16 + 4 + 1
  assign quo85  = 33'({quo_q, 6'b0}) + 33'({quo_q, 4'b0}) + 33'({quo_q, 2'b0}) + 33'(quo_q);
  assign diff   = v_q - quo85[31:0];
  assign wr_idx = 3'(a85_pkg::DigitCount - 1) - {1'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else if (take) begin
      hdr_q <= cmd_i;
      if (needs_dig) begin
        v_q     <= cmd_i.value;
        quo_q   <= quo_d;
        step_q  <= '0;
        state_q <= StSub;
      end else begin
        state_q <= StDone;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          state_q <= StIdle;
        end
        StMul: begin
          quo_q   <= quo_d;
          state_q <= StSub;
        end
        StSub: begin
          dig_q[wr_idx] <= diff[a85_pkg::DigitWidth-1:0];
          v_q           <= 32'(quo_q);
          if (step_q == 2'd3) begin
            // Last quotient is below 85: it is the leading digit
            dig_q[0] <= quo_q[a85_pkg::DigitWidth-1:0];
            state_q  <= StDone;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= StMul;
          end
        end
        StDone: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_valid_o     = (state_q == StDone);
  assign res_o.nl_first  = hdr_q.nl_first;
  assign res_o.has_grp   = hdr_q.has_grp;
  assign res_o.is_zero   = hdr_q.is_zero;
  assign res_o.ndig      = hdr_q.ndig;
  assign res_o.nl_second = hdr_q.nl_second;
  assign res_o.eod       = hdr_q.eod;
  assign res_o.digits    = dig_q;

endmodule

### src/a85_emit.sv
// ----------------------------------------------------------------------------
// a85_emit: character emitter
// Walks a slot mask of one converted command and drives one character per
// cycle, while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module a85_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_ready_o,
  input  a85_pkg::res_t  res_i,
  a85_out_if.source      out_o
);

  localparam int unsigned SlotCount    = 10;
  localparam int unsigned SlotNlFirst  = 0;
  localparam int unsigned SlotDigit0   = 1;
  localparam int unsigned SlotNlSecond = 6;
  localparam int unsigned SlotTilde    = 7;
  localparam int unsigned SlotGt       = 8;
  localparam int unsigned SlotEndNl    = 9;

  logic [SlotCount-1:0] mask_q, mask_d, mask_after, new_mask, low;
  logic [a85_pkg::DigitCount-1:0][a85_pkg::DigitWidth-1:0] dig_q;
  logic                 zero_q;
  logic                 ovalid_q;
  logic [7:0]           ochar_q, sel_char;
  logic                 olast_q, sel_last;
  logic                 out_load, res_take;

  always_comb begin
    new_mask = '0;
    new_mask[SlotNlFirst]  = res_i.nl_first;
    for (int k = 0; k < a85_pkg::DigitCount; k++) begin
      new_mask[SlotDigit0 + k] = res_i.has_grp &&
                                 (res_i.is_zero ? (k == 0) : (res_i.ndig > 3'(k)));
    end
    new_mask[SlotNlSecond] = res_i.nl_second;
    new_mask[SlotTilde]    = res_i.eod;
    new_mask[SlotGt]       = res_i.eod;
    new_mask[SlotEndNl]    = res_i.eod;
  end

  // Lowest pending slot goes out next
  assign low      = mask_q & (~mask_q + 1'b1);
  assign sel_last = ((mask_q & (mask_q - 1'b1)) == '0);

  always_comb begin
    sel_char = '0;
    if (low[SlotNlFirst] || low[SlotNlSecond] || low[SlotEndNl]) begin
      sel_char = a85_pkg::CharNl;
    end
    if (low[SlotTilde]) begin
      sel_char = a85_pkg::CharTilde;
    end
    if (low[SlotGt]) begin
      sel_char = a85_pkg::CharGt;
    end
    for (int k = 0; k < a85_pkg::DigitCount; k++) begin
      if (low[SlotDigit0 + k]) begin
        sel_char = zero_q ? a85_pkg::CharZero : 8'(dig_q[k]) + a85_pkg::CharBase;
      end
    end
  end

  assign out_load    = (mask_q != '0) && (!ovalid_q || out_o.ready);
  assign mask_after  = out_load ? (mask_q & ~low) : mask_q;
  assign res_ready_o = (mask_after == '0);
  assign res_take    = res_valid_i && res_ready_o;
  assign mask_d      = res_take ? new_mask : mask_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (res_take) begin
        dig_q  <= res_i.digits;
        zero_q <= res_i.is_zero;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
        ochar_q  <= sel_char;
        olast_q  <= sel_last;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_char    = ochar_q;
  assign out_o.last_of_run = olast_q;

endmodule

### src/ascii85_stream_encoder.sv
// Throughput: one input request per cycle while the 4-entry command queue has
//   room; the base-85 converter runs 4 multiply and subtract steps per non-zero
//   group and takes a new group only once its result has gone to the emitter;
//   output is one character per cycle while the output side is ready.
//   Reset (rst_ni low, async) empties all stages.
// ----------------------------------------------------------------------------
// ascii85_stream_encoder: ASCII85 text encoder for a byte stream
// Front packs bytes and tracks the column, a command queue decouples it from
// the converter; the emitter drives one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module ascii85_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  a85_in_if.sink      in_i,
  a85_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  // Front to queue: one command per request that produces characters
  logic          fq_valid, fq_ready;
  a85_pkg::cmd_t fq_cmd;

  // Queue to converter
  logic          qc_valid, qc_ready;
  a85_pkg::cmd_t qc_cmd;

  // Converter to emitter: digits ready, most significant first
  logic          ce_valid, ce_ready;
  a85_pkg::res_t ce_res;

  // Accept bytes, hold the partial group and the column, apply the line limit
  a85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // Buffer commands so the front keeps taking bytes during a conversion
  a85_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qc_valid),
    .pop_ready_i  (qc_ready),
    .pop_cmd_o    (qc_cmd)
  );

  // Split each group into base-85 digits; overlaps with the emitter
  a85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qc_valid),
    .cmd_ready_o (qc_ready),
    .cmd_i       (qc_cmd),
    .res_valid_o (ce_valid),
    .res_ready_i (ce_ready),
    .res_o       (ce_res)
  );

  // Serialize newlines, digits or 'z', and the end sequence
  a85_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (ce_valid),
    .res_ready_o (ce_ready),
    .res_i       (ce_res),
    .out_o       (out_o)
  );

endmodule
